// ===== sv/separable_image_convolution_macros.svh =====
// Assertion macros for the separable image convolution checker.
// Used by sic_checker; no other dependencies.
`ifndef SEPARABLE_IMAGE_CONVOLUTION_MACROS_SVH
`define SEPARABLE_IMAGE_CONVOLUTION_MACROS_SVH

// Clocked property, disabled during reset
`define SIC_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, also checked during reset
`define SIC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sic_pkg.sv =====
// Shared types, constants and tap selection for the separable convolution.
// No dependencies.
package sic_pkg;

  localparam int COL_W  = 14;  // column fields sized for the widest supported row
  localparam int SLOT_W = 5;   // slot fields sized for the largest window
  localparam int ROW_W  = 16;
  localparam int VS_W   = 18;
  localparam int HS_W   = 28;
  localparam int TAP_W  = 16;
  localparam int ACC_W  = 48;
  localparam int COEF_W = 4 * 64;
  localparam int QDEPTH = 4;

  localparam logic FN_PIXEL = 1'b0;
  localparam logic FN_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS, CFG_COEF0, CFG_COEF1, CFG_COEF2, CFG_COEF3
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [2:0]       radius;
  } geom_t;

  typedef struct packed {
    logic                    drain;
    logic [7:0]              pixel;
    logic [COL_W-1:0]        x;
    logic [SLOT_W-1:0]       sx;
    logic [SLOT_W-1:0]       sy;
    logic [COL_W-1:0]        lo;
    logic [COL_W-1:0]        hi;
    logic                    has_cols;
    logic                    out_en;
    logic                    last;
    logic signed [VS_W-1:0]  vstart;
    logic [SLOT_W-1:0]       vslot;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HINIT, ST_HRUN, ST_HWB, ST_VINIT, ST_VRUN, ST_VOUT, ST_NEXT
  } back_state_t;

  function automatic logic signed [TAP_W-1:0] tap_sel(input logic [COEF_W-1:0] coefs,
                                                      input logic [3:0] idx);
    logic signed [TAP_W-1:0] v;
    v = '0;
    if (idx != 4'd15) v = coefs[idx*TAP_W +: TAP_W];
    return v;
  endfunction

endpackage

// ===== sv/sic_cmd_fifo.sv =====
// Short command queue between the front and back of the convolution.
// Depends on sic_pkg.
module sic_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sic_pkg::cmd_t  din,
  input  logic           pop,
  output sic_pkg::cmd_t  dout,
  output logic           not_empty,
  output logic           full
);
  import sic_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  cmd_t            mem [QDEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;

  assign not_empty = count != '0;
  assign full      = count == (AW+1)'(QDEPTH);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

// ===== sv/sic_front.sv =====
// Front end: accepts transactions, tracks frame position, issues commands.
// Depends on sic_pkg.
module sic_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_RADIUS = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           restart,
  input  sic_pkg::geom_t geom,
  input  logic           in_accept,
  input  logic           func,
  input  logic [7:0]     pixel_in,
  output logic           push,
  output sic_pkg::cmd_t  cmd
);
  import sic_pkg::*;

  localparam int WIN  = 2 * MAX_RADIUS + 1;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int SLW  = $clog2(WIN);
  localparam int SO_W = SLW + 2;

  logic [XW-1:0]  x, dcol;
  logic [SLW-1:0] sx, sy;
  logic [ROW_W-1:0] y;
  logic [2:0]     drow;

  logic [2:0]     r, rows;
  logic [XW-1:0]  wm1, xmr;
  logic           draining, rowend, x_ge_r, h_lt_r, pix_ok, drain_ok, drain_last;
  logic signed [SO_W-1:0] r_s, soff, sdiff;
  logic [SLW-1:0] vslot_fix;
  logic signed [VS_W-1:0] vstart;

  always_comb begin
    r        = geom.radius;
    wm1      = geom.wm1[XW-1:0];
    draining = y > geom.hm1;
    rowend   = x == wm1;
    x_ge_r   = {1'b0, x} >= (XW+1)'(r);
    xmr      = x - XW'(r);
    h_lt_r   = ({1'b0, geom.hm1} + 17'd1) < 17'(r);
    rows     = h_lt_r ? geom.hm1[2:0] + 3'd1 : r;
    pix_ok   = !draining;
    drain_ok = draining && (r != 3'd0);
    drain_last = (drow == rows - 3'd1) && (dcol == wm1);
    r_s      = $signed(SO_W'(r));

    if (func == FN_PIXEL) begin
      soff   = -(r_s + r_s);
      vstart = $signed(VS_W'(y)) - $signed(VS_W'({r, 1'b0}));
    end else begin
      soff   = $signed(SO_W'(drow)) - $signed(SO_W'(rows)) - r_s;
      vstart = $signed(VS_W'(geom.hm1)) + 18'sd1 - $signed(VS_W'(rows))
             + $signed(VS_W'(drow)) - $signed(VS_W'(r));
    end
    sdiff     = $signed(SO_W'(sy)) + soff;
    vslot_fix = (sdiff < 0) ? SLW'(sdiff + $signed(SO_W'(WIN))) : SLW'(sdiff);

    cmd        = '0;
    cmd.drain  = func == FN_DRAIN;
    cmd.pixel  = pixel_in;
    cmd.x      = COL_W'(x);
    cmd.sx     = SLOT_W'(sx);
    cmd.sy     = SLOT_W'(sy);
    cmd.vstart = vstart;
    cmd.vslot  = (vstart < 0) ? '0 : SLOT_W'(vslot_fix);
    if (func == FN_PIXEL) begin
      cmd.lo       = COL_W'(rowend ? (x_ge_r ? xmr : '0) : xmr);
      cmd.hi       = COL_W'(rowend ? x : xmr);
      cmd.has_cols = rowend || x_ge_r;
      cmd.out_en   = y >= ROW_W'(r);
      cmd.last     = (r == 3'd0) && (y == geom.hm1) && rowend;
    end else begin
      cmd.lo       = COL_W'(dcol);
      cmd.hi       = COL_W'(dcol);
      cmd.has_cols = 1'b1;
      cmd.out_en   = 1'b1;
      cmd.last     = drain_last;
    end
    push = in_accept && ((func == FN_PIXEL) ? pix_ok : drain_ok);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      x <= '0; sx <= '0; y <= '0; sy <= '0; drow <= '0; dcol <= '0;
    end else if (in_accept) begin
      if (func == FN_PIXEL && pix_ok) begin
        if (rowend) begin
          x  <= '0;
          sx <= '0;
          if ((r == 3'd0) && (y == geom.hm1)) begin
            y  <= '0;
            sy <= '0;
          end else begin
            y  <= y + 1'b1;
            sy <= (sy == SLW'(WIN - 1)) ? '0 : sy + 1'b1;
          end
        end else begin
          x  <= x + 1'b1;
          sx <= (sx == SLW'(WIN - 1)) ? '0 : sx + 1'b1;
        end
      end else if (func == FN_DRAIN && drain_ok) begin
        if (drain_last) begin
          x <= '0; sx <= '0; y <= '0; sy <= '0; drow <= '0; dcol <= '0;
        end else if (dcol == wm1) begin
          dcol <= '0;
          drow <= drow + 1'b1;
        end else begin
          dcol <= dcol + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/sic_back.sv =====
// Back end: horizontal and vertical multiply-accumulate passes, row store,
// pixel window and output register. Depends on sic_pkg.
module sic_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_RADIUS = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sic_pkg::geom_t             geom,
  input  logic [sic_pkg::COEF_W-1:0] coefs,
  input  logic                       q_valid,
  input  sic_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [7:0]                 pixel_out,
  output logic                       frame_last
);
  import sic_pkg::*;

  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int SLW = $clog2(WIN);
  localparam int PW  = TAP_W + HS_W;

  back_state_t state, state_next;
  cmd_t        cmd;
  logic [XW-1:0]  xp;
  logic [3:0]     k, k_last;
  logic signed [VS_W-1:0] t, t_next, bound, hstart, hsd;
  logic [SLW-1:0] slot, slot_step, hslot;
  logic           pend, issuing, run_done, step, running, out_load;
  logic signed [TAP_W-1:0] ptap;
  logic signed [ACC_W-1:0] acc;
  logic signed [HS_W-1:0]  opnd;
  logic signed [PW-1:0]    prod;
  logic [7:0]     win_q, vpix;
  logic [HS_W-1:0] row_q;
  logic [ACC_W-HS_W-1:0] qhi;

  logic [7:0]      win_mem [WIN];
  logic [HS_W-1:0] row_mem [WIN][MAX_WIDTH];

  always_comb begin
    k_last   = {geom.radius, 1'b0};
    running  = (state == ST_HRUN) || (state == ST_VRUN);
    issuing  = running && (k <= k_last);
    run_done = (k > k_last) && !pend;
    bound    = (state == ST_HRUN) ? $signed(VS_W'(geom.wm1)) : $signed(VS_W'(geom.hm1));
    t_next   = t + 18'sd1;
    step     = (t_next >= 18'sd1) && (t_next <= bound);
    slot_step = step ? ((slot == SLW'(WIN - 1)) ? '0 : slot + 1'b1) : slot;
    opnd     = (state == ST_HRUN) ? $signed({{(HS_W-8){1'b0}}, win_q}) : $signed(row_q);
    prod     = ptap * opnd;
    hstart   = $signed(VS_W'(xp)) - $signed(VS_W'(geom.radius));
    hsd      = $signed(VS_W'(cmd.sx)) + $signed(VS_W'(xp)) - $signed(VS_W'(cmd.x))
             - $signed(VS_W'(geom.radius));
    hslot    = (hsd < 0) ? SLW'(hsd + $signed(VS_W'(WIN))) : SLW'(hsd);
    qhi      = acc[ACC_W-1:HS_W];
    if (acc[ACC_W-1] || acc == '0) vpix = 8'd0;
    else if (qhi > (ACC_W-HS_W)'(255)) vpix = 8'd255;
    else vpix = qhi[7:0];
    out_load = (state == ST_VOUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.drain) state_next = ST_VINIT;
          else if (q_cmd.has_cols) state_next = ST_HINIT;
        end
      end
      ST_HINIT: state_next = ST_HRUN;
      ST_HRUN:  if (run_done) state_next = ST_HWB;
      ST_HWB:   state_next = cmd.out_en ? ST_VINIT : ST_NEXT;
      ST_VINIT: state_next = ST_VRUN;
      ST_VRUN:  if (run_done) state_next = ST_VOUT;
      ST_VOUT:  if (out_load) state_next = ST_NEXT;
      ST_NEXT:  state_next = (xp == cmd.hi[XW-1:0]) ? ST_IDLE : ST_HINIT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cmd <= q_cmd;
          xp  <= q_cmd.lo[XW-1:0];
        end
      end
      ST_HINIT: begin
        t    <= hstart;
        slot <= (hstart < 0) ? '0 : hslot;
        k    <= '0;
        acc  <= '0;
        pend <= 1'b0;
      end
      ST_VINIT: begin
        t    <= cmd.vstart;
        slot <= cmd.vslot[SLW-1:0];
        k    <= '0;
        acc  <= '0;
        pend <= 1'b0;
      end
      ST_HRUN, ST_VRUN: begin
        if (pend) acc <= acc + {{(ACC_W-PW){prod[PW-1]}}, prod};
        if (issuing) begin
          pend <= 1'b1;
          ptap <= tap_sel(coefs, k);
          k    <= k + 1'b1;
          t    <= t_next;
          slot <= slot_step;
        end else begin
          pend <= 1'b0;
        end
      end
      ST_NEXT: xp <= xp + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && !q_cmd.drain) win_mem[q_cmd.sx[SLW-1:0]] <= q_cmd.pixel;
    win_q <= win_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (state == ST_HWB) row_mem[cmd.sy[SLW-1:0]][xp] <= acc[HS_W-1:0];
    row_q <= row_mem[slot][xp];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_out  <= vpix;
      frame_last <= cmd.last;
    end
  end

endmodule

// ===== sv/separable_image_convolution.sv =====
// Channel  | Handshake              | Payload
// input    | in_valid / in_stall    | func, pixel_in
// output   | out_valid / out_stall  | pixel_out, frame_last
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
// An output column runs a horizontal pass (init, 2R + 1 taps, the last pending
// product, write-back), then a vertical pass (init, taps, output), plus any output stall.
// A pixel transaction is popped in the idle state and triggers 0..R+1 columns; a column
// with no output runs only the horizontal pass. A drain transaction runs only the vertical pass.
// Synchronous reset; no clearing pass, the stores need none.
// The front keeps accepting while the queue has room; a stalled output stops the back.
// Top level: config registers, front, command queue, back. Depends on sic_pkg,
// sic_front, sic_cmd_fifo, sic_back.
module separable_image_convolution #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_RADIUS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_out,
  output logic        frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import sic_pkg::*;

  logic [12:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  kernel_radius;
  logic [63:0] coef_word_0, coef_word_1, coef_word_2, coef_word_3;

  geom_t geom;
  cmd_t  f_cmd, q_cmd;
  logic  cfg_we, restart, in_accept, push, pop, q_valid, q_full;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT
                                || cfg_index == CFG_RADIUS);
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (image_width == 13'd0) geom.wm1 = '0;
    else if (int'(image_width) > MAX_WIDTH) geom.wm1 = COL_W'(MAX_WIDTH - 1);
    else geom.wm1 = COL_W'(image_width - 13'd1);
    geom.hm1    = (image_height == 16'd0) ? '0 : image_height - 16'd1;
    geom.radius = (int'(kernel_radius) > MAX_RADIUS) ? 3'(MAX_RADIUS) : kernel_radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 13'd64;
      image_height  <= 16'd64;
      kernel_radius <= 3'd1;
      coef_word_0   <= '0;
      coef_word_1   <= '0;
      coef_word_2   <= '0;
      coef_word_3   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH:  image_width   <= cfg_data[12:0];
        CFG_HEIGHT: image_height  <= cfg_data[15:0];
        CFG_RADIUS: kernel_radius <= cfg_data[2:0];
        CFG_COEF0:  coef_word_0   <= cfg_data;
        CFG_COEF1:  coef_word_1   <= cfg_data;
        CFG_COEF2:  coef_word_2   <= cfg_data;
        CFG_COEF3:  coef_word_3   <= cfg_data;
        default: ;
      endcase
    end
  end

  sic_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk(clk), .rst(rst), .restart(restart), .geom(geom),
    .in_accept(in_accept), .func(func), .pixel_in(pixel_in),
    .push(push), .cmd(f_cmd)
  );

  sic_cmd_fifo u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_cmd), .pop(pop),
    .dout(q_cmd), .not_empty(q_valid), .full(q_full)
  );

  sic_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk(clk), .rst(rst), .geom(geom),
    .coefs({coef_word_3, coef_word_2, coef_word_1, coef_word_0}),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(pop),
    .out_stall(out_stall), .out_valid(out_valid),
    .pixel_out(pixel_out), .frame_last(frame_last)
  );

endmodule

// ===== sv/sic_checker.sv =====
// Port-level checks for separable_image_convolution, bound to the top level.
// Depends on separable_image_convolution_macros.svh.
`include "separable_image_convolution_macros.svh"

module sic_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel_out,
  input logic       frame_last,
  input logic       cfg_ready
);

  `SIC_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_last), "output transaction changed while stalled")
  `SIC_ASSERT(a_rst_no_out, clk, rst |=> !out_valid, "output valid right after reset")
  `SIC_ASSERT(a_rst_queue_free, clk, rst |=> !in_stall, "input stalled right after reset")
  `SIC_ASSERT_RST(a_cfg_ready, clk, rst, cfg_ready, "config port not ready")

endmodule

bind separable_image_convolution sic_checker u_sic_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .pixel_out(pixel_out), .frame_last(frame_last),
  .cfg_ready(cfg_ready)
);
